// ----- rtl/ppb_pkg.sv -----
// Shared codes, controller states and command/status types of the pairwise projection bitset.
package ppb_pkg;

   // Item kinds
   localparam logic [2:0] KIND_OPEN   = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_CLEAR  = 3'd2;
   localparam logic [2:0] KIND_TUPLE  = 3'd3;
   localparam logic [2:0] KIND_VQUERY = 3'd4;
   localparam logic [2:0] KIND_PQUERY = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CAPACITY = 2'd1;
   localparam logic [1:0] STATUS_POSITION = 2'd2;

   // Seen store row geometry and bound compare width
   localparam int SEEN_ROW_W = 64;
   localparam int SEEN_BIT_W = $clog2(SEEN_ROW_W);
   localparam int CMP_W      = 32;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_TBL_READ,
      ST_TBL_WAIT,
      ST_TBL2_READ,
      ST_TBL2_WAIT,
      ST_VERTEX_SET,
      ST_PAIR_MUL,
      ST_PAIR_SET,
      ST_SEEN_READ,
      ST_SEEN_WAIT,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic sweep_step;
      logic sweep_table;
      logic loop_clear;
      logic loop_step;
      logic tbl_rd;
      logic sel_second;
      logic rank_load;
      logic first_load;
      logic mul_load;
      logic mul_pair;
      logic seen_set;
      logic seen_rd;
      logic idx_pair;
      logic hit_load;
      logic post;
   } ppb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_clear;
      logic is_tuple;
      logic is_vquery;
      logic is_pquery;
      logic chk_ok;
      logic sweep_last;
      logic loop_done;
      logic loop_last;
   } ppb_sts_type;

endpackage

// ----- rtl/pairwise_projection_bitset.sv -----
// Top level of the pairwise projection bitset: controller plus datapath.
// A tuple argument at position p sets its own vertex bit, then takes one multiply and one bit
// write per earlier argument, all through the single seen store write port; a clear zeroes
// every seen row in turn. A new item is taken only in the idle state, once the previous item
// has posted its result; the next item may start while a result waits.
// Synchronous reset; afterwards a clearing pass over max(seen rows, rank table entries)
// addresses (16384 with the default sizes) zeroes both stores before the first item is taken.
module pairwise_projection_bitset import ppb_pkg::*; #(
   parameter int MAX_POSITIONS = 8,
   parameter int MAX_OBJECTS   = 64,
   parameter int MAX_RANKS     = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [5:0] req_object,
   input  logic [2:0] req_position,
   input  logic [2:0] req_second_position,
   input  logic [5:0] req_second_object,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_hit,
   output logic [1:0] rsp_status
);

   ppb_cmd_type cmd;
   ppb_sts_type sts;

   ppb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppb_datapath #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .MAX_OBJECTS   (MAX_OBJECTS),
      .MAX_RANKS     (MAX_RANKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_object          (req_object),
      .req_position        (req_position),
      .req_second_position (req_second_position),
      .req_second_object   (req_second_object),
      .req_last            (req_last),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_hit             (rsp_hit),
      .rsp_status          (rsp_status)
   );

endmodule

// ----- rtl/ppb_ram.sv -----
// Generic simple dual-port RAM with bit write mask and registered read.
module ppb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [WIDTH-1:0]  wr_mask,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write masked bits, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < WIDTH; b++) begin
            if (wr_mask[b]) begin
               mem_ff[wr_addr][b] <= wr_data[b];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ppb_ctrl.sv -----
// Controller state machine: sequences sweeps, lookups, bit writes and result posting.
module ppb_ctrl import ppb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ppb_sts_type sts,
   output ppb_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!sts.chk_ok) begin
               state_in = ST_FINISH;
            end else if (sts.is_clear) begin
               state_in = ST_CLEAR;
            end else if (sts.is_tuple || sts.is_vquery || sts.is_pquery) begin
               state_in = ST_TBL_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            if (sts.sweep_last) state_in = ST_FINISH;
         end
         ST_TBL_READ: state_in = ST_TBL_WAIT;
         ST_TBL_WAIT: begin
            if (sts.is_pquery) begin
               state_in = ST_TBL2_READ;
            end else if (sts.is_tuple) begin
               state_in = ST_VERTEX_SET;
            end else begin
               state_in = ST_SEEN_READ;
            end
         end
         ST_TBL2_READ: state_in = ST_TBL2_WAIT;
         ST_TBL2_WAIT: state_in = ST_PAIR_MUL;
         ST_VERTEX_SET: begin
            state_in = sts.loop_done ? ST_FINISH : ST_PAIR_MUL;
         end
         ST_PAIR_MUL: begin
            state_in = sts.is_pquery ? ST_SEEN_READ : ST_PAIR_SET;
         end
         ST_PAIR_SET: begin
            state_in = sts.loop_last ? ST_FINISH : ST_PAIR_MUL;
         end
         ST_SEEN_READ: state_in = ST_SEEN_WAIT;
         ST_SEEN_WAIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step  = 1'b1;
            cmd.sweep_table = 1'b1;
         end
         ST_IDLE: cmd.accept = req_valid;
         ST_DECODE: cmd.loop_clear = 1'b1;
         ST_CLEAR: cmd.sweep_step = 1'b1;
         ST_TBL_READ: cmd.tbl_rd = 1'b1;
         ST_TBL_WAIT: begin
            cmd.first_load = sts.is_pquery;
            cmd.rank_load  = !sts.is_pquery;
         end
         ST_TBL2_READ: begin
            cmd.tbl_rd     = 1'b1;
            cmd.sel_second = 1'b1;
         end
         ST_TBL2_WAIT: begin
            cmd.sel_second = 1'b1;
            cmd.rank_load  = 1'b1;
         end
         ST_VERTEX_SET: cmd.seen_set = 1'b1;
         ST_PAIR_MUL: begin
            cmd.mul_load = 1'b1;
            cmd.mul_pair = sts.is_pquery;
         end
         ST_PAIR_SET: begin
            cmd.seen_set  = 1'b1;
            cmd.idx_pair  = 1'b1;
            cmd.loop_step = 1'b1;
         end
         ST_SEEN_READ: begin
            cmd.seen_rd  = 1'b1;
            cmd.idx_pair = sts.is_pquery;
         end
         ST_SEEN_WAIT: begin
            cmd.hit_load = 1'b1;
            cmd.idx_pair = sts.is_pquery;
         end
         ST_FINISH: cmd.post = out_free;
         default: cmd = '0;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_post_before_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.post))
      else $error("result valid rose without a post");

   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("still ready after accepting an item");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SWEEP) && $past(state_ff == ST_SWEEP) |-> $past(sts.sweep_last))
      else $error("reset sweep left before its last row");
`endif

endmodule

// ----- rtl/ppb_datapath.sv -----
// Datapath: item registers, rank bookkeeping, rank table and seen bit store.
module ppb_datapath import ppb_pkg::*; #(
   parameter int MAX_POSITIONS = 8,
   parameter int MAX_OBJECTS   = 64,
   parameter int MAX_RANKS     = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_object,
   input  logic [2:0]  req_position,
   input  logic [2:0]  req_second_position,
   input  logic [5:0]  req_second_object,
   input  logic        req_last,
   input  ppb_cmd_type cmd,
   output ppb_sts_type sts,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status
);

   localparam int POS_AW      = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int DOM_W       = $clog2(MAX_POSITIONS + 1);
   localparam int OBJ_AW      = $clog2(MAX_OBJECTS);
   localparam int FILL_W      = $clog2(MAX_OBJECTS + 1);
   localparam int RANK_W      = $clog2(MAX_RANKS);
   localparam int TOT_W       = $clog2(MAX_RANKS + 1);
   localparam int SUM_W       = RANK_W + FILL_W;
   localparam int MUL_W       = RANK_W + TOT_W;
   localparam int IDX_W       = $clog2(MAX_RANKS * MAX_RANKS);
   localparam int SEEN_ROWS   = (MAX_RANKS * MAX_RANKS + SEEN_ROW_W - 1) / SEEN_ROW_W;
   localparam int ROW_AW      = $clog2(SEEN_ROWS);
   localparam int TBL_AW      = POS_AW + OBJ_AW;
   localparam int TBL_DEPTH   = 1 << TBL_AW;
   localparam int SWEEP_DEPTH = (SEEN_ROWS > TBL_DEPTH) ? SEEN_ROWS : TBL_DEPTH;
   localparam int SWEEP_W     = $clog2(SWEEP_DEPTH);

   // Item registers
   logic [2:0]  kind_ff;
   logic [5:0]  obj_ff;
   logic [2:0]  pos_ff;
   logic [2:0]  pos2_ff;
   logic [5:0]  obj2_ff;
   logic        last_ff;

   // Bookkeeping registers
   logic [TOT_W-1:0]   rt_ff,    rt_in;
   logic [DOM_W-1:0]   dom_ff,   dom_in;
   logic [FILL_W-1:0]  fill_ff,  fill_in;
   logic [DOM_W-1:0]   tix_ff,   tix_in;
   logic [DOM_W-1:0]   loop_ff,  loop_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic [RANK_W-1:0]  base_ff   [MAX_POSITIONS];
   logic [RANK_W-1:0]  tranks_ff [MAX_POSITIONS];

   // Work registers
   logic [RANK_W-1:0] r_ff;
   logic [RANK_W-1:0] j1_ff;
   logic [IDX_W-1:0]  prod_ff;
   logic              hit_ff;
   logic              rsp_hit_ff;
   logic [1:0]        rsp_status_ff;

   logic [1:0]            status_code;
   logic [1:0]            chk1, chk2, chkt;
   logic                  is_open, is_add, is_clear, is_tuple, is_vquery, is_pquery, ok;
   logic                  open_commit, add_commit, tuple_commit, tuple_end;
   logic [DOM_W-1:0]      dom_m1;
   logic [FILL_W-1:0]     fill_next;
   logic [POS_AW-1:0]     pos_idx;
   logic [OBJ_AW-1:0]     obj_idx;
   logic [RANK_W-1:0]     rank_sum;
   logic [RANK_W-1:0]     mul_a;
   logic [MUL_W-1:0]      mul_full;
   logic [IDX_W-1:0]      idx;
   logic [ROW_AW-1:0]     idx_row;
   logic                  sweep_last;
   logic                  tbl_wr_en;
   logic [TBL_AW-1:0]     tbl_wr_addr;
   logic [FILL_W-1:0]     tbl_wr_data;
   logic [FILL_W-1:0]     tbl_rd_data;
   logic                  seen_wr_en;
   logic [ROW_AW-1:0]     seen_wr_addr;
   logic [SEEN_ROW_W-1:0] seen_wr_data;
   logic [SEEN_ROW_W-1:0] seen_wr_mask;
   logic [SEEN_ROW_W-1:0] seen_rd_data;

   // Position then object bound check of one argument
   function automatic logic [1:0] check_arg(input logic [CMP_W-1:0] p,
                                            input logic [CMP_W-1:0] o,
                                            input logic [CMP_W-1:0] dom);
      logic [1:0] code;
      code = STATUS_OK;
      if (p >= dom || p >= CMP_W'(MAX_POSITIONS)) begin
         code = STATUS_POSITION;
      end else if (o >= CMP_W'(MAX_OBJECTS)) begin
         code = STATUS_CAPACITY;
      end
      return code;
   endfunction

   // Decode kind
   assign is_open   = (kind_ff == KIND_OPEN);
   assign is_add    = (kind_ff == KIND_ADD);
   assign is_clear  = (kind_ff == KIND_CLEAR);
   assign is_tuple  = (kind_ff == KIND_TUPLE);
   assign is_vquery = (kind_ff == KIND_VQUERY);
   assign is_pquery = (kind_ff == KIND_PQUERY);

   assign chk1 = check_arg(CMP_W'(pos_ff), CMP_W'(obj_ff), CMP_W'(dom_ff));
   assign chk2 = check_arg(CMP_W'(pos2_ff), CMP_W'(obj2_ff), CMP_W'(dom_ff));
   assign chkt = check_arg(CMP_W'(tix_ff), CMP_W'(obj_ff), CMP_W'(dom_ff));

   // Status of the current item; state changes only at post, so this holds till then
   always_comb begin
      status_code = STATUS_OK;
      case (kind_ff)
         KIND_OPEN: begin
            if (CMP_W'(dom_ff) >= CMP_W'(MAX_POSITIONS)) begin
               status_code = STATUS_POSITION;
            end else if (CMP_W'(rt_ff) >= CMP_W'(MAX_RANKS)) begin
               status_code = STATUS_CAPACITY;
            end
         end
         KIND_ADD: begin
            if (dom_ff == '0) begin
               status_code = STATUS_POSITION;
            end else if (CMP_W'(rt_ff) >= CMP_W'(MAX_RANKS) ||
                         CMP_W'(fill_ff) >= CMP_W'(MAX_OBJECTS) ||
                         CMP_W'(obj_ff) >= CMP_W'(MAX_OBJECTS)) begin
               status_code = STATUS_CAPACITY;
            end
         end
         KIND_TUPLE:  status_code = chkt;
         KIND_VQUERY: status_code = chk1;
         KIND_PQUERY: begin
            if (chk1 == STATUS_POSITION || chk2 == STATUS_POSITION) begin
               status_code = STATUS_POSITION;
            end else if (chk1 != STATUS_OK || chk2 != STATUS_OK) begin
               status_code = STATUS_CAPACITY;
            end
         end
         default: status_code = STATUS_OK;
      endcase
   end

   assign ok = (status_code == STATUS_OK);

   // Commit points, all at post
   assign open_commit  = cmd.post && is_open && ok;
   assign add_commit   = cmd.post && is_add && ok;
   assign tuple_commit = cmd.post && is_tuple && ok;
   assign tuple_end    = cmd.post && is_tuple && last_ff;

   assign dom_m1    = dom_ff - DOM_W'(1);
   assign fill_next = fill_ff + FILL_W'(1);

   // Select the argument being looked up
   assign pos_idx = is_tuple ? tix_ff[POS_AW-1:0] :
                    (cmd.sel_second ? POS_AW'(pos2_ff) : POS_AW'(pos_ff));
   assign obj_idx = cmd.sel_second ? OBJ_AW'(obj2_ff) : OBJ_AW'(obj_ff);

   // Rank = position base + table entry
   assign rank_sum = RANK_W'(SUM_W'(base_ff[pos_idx]) + SUM_W'(tbl_rd_data));

   // First rank times total ranks
   assign mul_a    = cmd.mul_pair ? j1_ff : tranks_ff[loop_ff[POS_AW-1:0]];
   assign mul_full = MUL_W'(mul_a) * MUL_W'(rt_ff);

   // Bit index in the seen store
   assign idx     = cmd.idx_pair ? IDX_W'(prod_ff + IDX_W'(r_ff)) : IDX_W'(r_ff);
   assign idx_row = idx[SEEN_BIT_W +: ROW_AW];

   // Sweep end depends on which stores are swept
   assign sweep_last = cmd.sweep_table ? (sweep_ff == SWEEP_W'(SWEEP_DEPTH - 1)) :
                                         (sweep_ff == SWEEP_W'(SEEN_ROWS - 1));

   // Next values of bookkeeping registers
   always_comb begin
      rt_in    = rt_ff;
      dom_in   = dom_ff;
      fill_in  = fill_ff;
      tix_in   = tix_ff;
      loop_in  = loop_ff;
      sweep_in = sweep_ff;
      if (open_commit || add_commit) rt_in = rt_ff + TOT_W'(1);
      if (open_commit) begin
         dom_in  = dom_ff + DOM_W'(1);
         fill_in = '0;
      end else if (add_commit) begin
         fill_in = fill_next;
      end
      if (tuple_end) begin
         tix_in = '0;
      end else if (tuple_commit) begin
         tix_in = tix_ff + DOM_W'(1);
      end
      if (cmd.loop_clear) begin
         loop_in = '0;
      end else if (cmd.loop_step) begin
         loop_in = loop_ff + DOM_W'(1);
      end
      if (cmd.sweep_step) begin
         sweep_in = sweep_last ? '0 : sweep_ff + SWEEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_ff    <= TOT_W'(1);
         dom_ff   <= '0;
         fill_ff  <= '0;
         tix_ff   <= '0;
         loop_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         rt_ff    <= rt_in;
         dom_ff   <= dom_in;
         fill_ff  <= fill_in;
         tix_ff   <= tix_in;
         loop_ff  <= loop_in;
         sweep_ff <= sweep_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         obj_ff  <= req_object;
         pos_ff  <= req_position;
         pos2_ff <= req_second_position;
         obj2_ff <= req_second_object;
         last_ff <= req_last;
      end
      if (open_commit) base_ff[dom_ff[POS_AW-1:0]] <= RANK_W'(rt_ff);
      if (tuple_commit) tranks_ff[tix_ff[POS_AW-1:0]] <= r_ff;
      if (cmd.rank_load) r_ff <= rank_sum;
      if (cmd.first_load) j1_ff <= rank_sum;
      if (cmd.mul_load) prod_ff <= IDX_W'(mul_full);
      if (cmd.hit_load) hit_ff <= seen_rd_data[idx[SEEN_BIT_W-1:0]];
      if (cmd.post) begin
         rsp_status_ff <= status_code;
         rsp_hit_ff    <= (is_vquery || is_pquery) && ok && hit_ff;
      end
   end

   // Rank table port: sweep zeroes, add writes the new fill
   assign tbl_wr_en   = (cmd.sweep_step && cmd.sweep_table &&
                         CMP_W'(sweep_ff) < CMP_W'(TBL_DEPTH)) || add_commit;
   assign tbl_wr_addr = cmd.sweep_step ? sweep_ff[TBL_AW-1:0] :
                        {dom_m1[POS_AW-1:0], OBJ_AW'(obj_ff)};
   assign tbl_wr_data = cmd.sweep_step ? '0 : fill_next;

   ppb_ram #(
      .WIDTH (FILL_W),
      .DEPTH (TBL_DEPTH)
   ) u_rank_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .wr_mask ({FILL_W{1'b1}}),
      .rd_en   (cmd.tbl_rd),
      .rd_addr ({pos_idx, obj_idx}),
      .rd_data (tbl_rd_data)
   );

   // Seen store port: sweep zeroes rows, set writes one masked bit
   assign seen_wr_en   = (cmd.sweep_step && CMP_W'(sweep_ff) < CMP_W'(SEEN_ROWS)) ||
                         cmd.seen_set;
   assign seen_wr_addr = cmd.sweep_step ? sweep_ff[ROW_AW-1:0] : idx_row;
   assign seen_wr_data = cmd.sweep_step ? '0 : '1;
   assign seen_wr_mask = cmd.sweep_step ? '1 :
                         (SEEN_ROW_W'(1) << idx[SEEN_BIT_W-1:0]);

   ppb_ram #(
      .WIDTH (SEEN_ROW_W),
      .DEPTH (SEEN_ROWS)
   ) u_seen_store (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .wr_mask (seen_wr_mask),
      .rd_en   (cmd.seen_rd),
      .rd_addr (idx_row),
      .rd_data (seen_rd_data)
   );

   // Status to controller
   always_comb begin
      sts            = '0;
      sts.is_clear   = is_clear;
      sts.is_tuple   = is_tuple;
      sts.is_vquery  = is_vquery;
      sts.is_pquery  = is_pquery;
      sts.chk_ok     = ok;
      sts.sweep_last = sweep_last;
      sts.loop_done  = (loop_ff == tix_ff);
      sts.loop_last  = ((loop_ff + DOM_W'(1)) == tix_ff);
   end

   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_tix_within_domains: assert property (@(posedge clock) disable iff (reset)
      tix_ff <= dom_ff)
      else $error("tuple position beyond opened domains");

   a_ranks_cover_bases: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(rt_ff) >= CMP_W'(dom_ff) + CMP_W'(1))
      else $error("rank total below opened domains plus one");

   a_hit_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_load |-> $past(cmd.seen_rd))
      else $error("hit sampled without a preceding seen read");
`endif

endmodule
